@@ src/sib_pkg.sv @@
package sib_pkg;

   localparam int CAPACITY   = 16;
   localparam int INDEX_BITS = 16;

   // stored width: the value field is 16 bits, of which only INDEX_BITS are kept
   localparam int STORE_BITS = (INDEX_BITS < 16) ? INDEX_BITS : 16;
   localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DUMP   = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_INS_SCAN,
      STATE_INS_PLACE,
      STATE_DUMP
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [STORE_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
   } mem_req_type;

endpackage

@@ src/sib_ram.sv @@
module sib_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sib_ctrl.sv @@
module sib_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // value
   input  logic [1:0]                      req_tuser,  // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // entry
   output logic                            rsp_tlast,
   output logic [1:0]                      rsp_tuser,  // status
   output sib_pkg::mem_req_type            mem_req,
   input  logic [sib_pkg::STORE_BITS-1:0]  mem_rd_data
);

   sib_pkg::state_type                    state_ff, state_in;
   logic [sib_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   logic [sib_pkg::ADDR_BITS-1:0]         idx_ff, idx_in;
   logic [sib_pkg::STORE_BITS-1:0]        value_ff, value_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [sib_pkg::STORE_BITS-1:0]        rsp_entry_ff, rsp_entry_in;
   logic                                  rsp_last_ff, rsp_last_in;
   sib_pkg::status_type                   rsp_status_ff, rsp_status_in;

   logic                                  accept;
   logic                                  out_free;
   logic                                  full;
   logic                                  scan_greater;
   logic                                  dump_last;
   logic                                  dump_load;
   sib_pkg::opcode_type                   opcode;

   assign opcode       = sib_pkg::opcode_type'(req_tuser);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == sib_pkg::STATE_IDLE) && out_free;
   assign accept       = req_tvalid && req_tready;
   assign full         = (count_ff == sib_pkg::COUNT_BITS'(sib_pkg::CAPACITY));
   assign scan_greater = (mem_rd_data > value_ff);
   assign dump_last    = (sib_pkg::COUNT_BITS'(idx_ff) == count_ff - sib_pkg::COUNT_BITS'(1));
   assign dump_load    = (state_ff == sib_pkg::STATE_DUMP) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sib_pkg::STATE_IDLE: begin
            if (accept) begin
               unique case (opcode)
                  sib_pkg::OP_INSERT: begin
                     if (!full) begin
                        state_in = (count_ff == '0) ? sib_pkg::STATE_INS_PLACE
                                                    : sib_pkg::STATE_INS_SCAN;
                     end
                  end
                  sib_pkg::OP_DUMP: begin
                     if (count_ff != '0) begin
                        state_in = sib_pkg::STATE_DUMP;
                     end
                  end
                  default: state_in = sib_pkg::STATE_IDLE;
               endcase
            end
         end
         sib_pkg::STATE_INS_SCAN: begin
            if (!scan_greater) begin
               state_in = sib_pkg::STATE_IDLE;
            end else if (idx_ff == '0) begin
               state_in = sib_pkg::STATE_INS_PLACE;
            end
         end
         sib_pkg::STATE_INS_PLACE: begin
            state_in = sib_pkg::STATE_IDLE;
         end
         sib_pkg::STATE_DUMP: begin
            if (dump_load && dump_last) begin
               state_in = sib_pkg::STATE_IDLE;
            end
         end
         default: state_in = sib_pkg::STATE_IDLE;
      endcase
   end

   // datapath and memory requests
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mem_req       = '0;

      unique case (state_ff)
         sib_pkg::STATE_IDLE: begin
            if (accept) begin
               value_in      = sib_pkg::STORE_BITS'(req_tdata);
               rsp_entry_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = sib_pkg::STATUS_OK;
               unique case (opcode)
                  sib_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = sib_pkg::STATUS_FULL;
                     end else begin
                        count_in = count_ff + sib_pkg::COUNT_BITS'(1);
                        // scan starts at the top entry and walks down
                        idx_in   = sib_pkg::ADDR_BITS'(count_ff - sib_pkg::COUNT_BITS'(1));
                        mem_req.rd_en   = (count_ff != '0);
                        mem_req.rd_addr = sib_pkg::ADDR_BITS'(count_ff - sib_pkg::COUNT_BITS'(1));
                     end
                  end
                  sib_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = sib_pkg::STATUS_EMPTY;
                     end else begin
                        idx_in          = '0;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                     end
                  end
                  sib_pkg::OP_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                  end
                  default: rsp_valid_in = rsp_valid_ff && !rsp_tready;
               endcase
            end
         end
         sib_pkg::STATE_INS_SCAN: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff + sib_pkg::ADDR_BITS'(1);
            if (scan_greater) begin
               // move the larger entry up one slot
               mem_req.wr_data = mem_rd_data;
               if (idx_ff != '0) begin
                  idx_in          = idx_ff - sib_pkg::ADDR_BITS'(1);
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff - sib_pkg::ADDR_BITS'(1);
               end
            end else begin
               mem_req.wr_data = value_ff;
            end
         end
         sib_pkg::STATE_INS_PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = '0;
            mem_req.wr_data = value_ff;
         end
         sib_pkg::STATE_DUMP: begin
            if (dump_load) begin
               rsp_valid_in  = 1'b1;
               rsp_entry_in  = mem_rd_data;
               rsp_last_in   = dump_last;
               rsp_status_in = sib_pkg::STATUS_OK;
               if (!dump_last) begin
                  idx_in          = idx_ff + sib_pkg::ADDR_BITS'(1);
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff + sib_pkg::ADDR_BITS'(1);
               end
            end
         end
         default: mem_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sib_pkg::STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_entry_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sib_pkg::COUNT_BITS'(sib_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_no_same_addr: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("read and write hit the same entry");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (sib_pkg::COUNT_BITS'(mem_req.wr_addr) < count_ff))
      else $error("write beyond the filled part of the store");

   a_dump_ends: assert property (@(posedge clock) disable iff (reset)
      (dump_load && dump_last) |=> (state_ff == sib_pkg::STATE_IDLE) && rsp_tvalid && rsp_tlast)
      else $error("dump did not close with a last item");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sib_pkg::STATE_IDLE) |-> !req_tready)
      else $error("input taken while store is busy");
`endif

endmodule

@@ src/sorted_insert_buffer_core.sv @@
// Sorted insertion list of up to CAPACITY indices held in a single-port-write,
// single-port-read RAM. Opcode rides in req_tuser (0 insert, 1 dump, 2 clear,
// 3 ignored), the value in req_tdata. Insert and clear answer with one item on
// the cycle after they are taken (status in rsp_tuser: 0 ok, 1 full and
// dropped). A stored insert then keeps the block busy while the RAM walks from
// the top entry down, moving each larger entry up one slot, so equal values
// keep arrival order. A dropped insert, a clear, an empty dump and an ignored
// opcode leave the block idle. A dump streams the entries in ascending order in
// rsp_tdata, the first one passing through the RAM read register and then the
// output register, and then one per cycle while rsp_tready stays high, with
// rsp_tlast on the final one; an empty store gives a single item with status 2.
// The next request is taken only once the RAM walk of the previous one is done
// and the output register is empty or being read.
module sorted_insert_buffer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // entry[15:0]
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   sib_pkg::mem_req_type                mem_req;
   logic [sib_pkg::STORE_BITS-1:0]      mem_rd_data;

   sib_ram #(
      .DEPTH (sib_pkg::CAPACITY),
      .WIDTH (sib_pkg::STORE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   sib_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

endmodule
